/* src/spq_pkg.sv */
// ---------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue and its cells.
// ---------------------------------------------------------------------------
package spq_pkg;

   localparam int DEPTH       = 64;
   localparam int KEY_WIDTH   = 32;
   localparam int TAG_WIDTH   = 16;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);

   typedef logic [KEY_WIDTH-1:0]   key_type;
   typedef logic [TAG_WIDTH-1:0]   tag_type;
   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_POP    = 1'b1
   } op_type;

   typedef struct packed {
      key_type key;
      tag_type payload;
   } entry_type;

   // Broadcast to every cell in the chain for one beat.
   typedef struct packed {
      logic      insert;
      logic      pop;
      entry_type entry;
   } cmd_type;

endpackage

/* src/spq_cell.sv */
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry and, on each command, keeps
// it, takes the new entry, or takes the entry of a neighbouring slot.
// ---------------------------------------------------------------------------
module spq_cell
   import spq_pkg::*;
(
   input  logic      clock,
   input  cmd_type   cmd,
   input  logic      occupied,
   input  logic      left_keep,
   input  entry_type left_entry,
   input  entry_type right_entry,
   output logic      keep,
   output entry_type entry,
   output entry_type entry_next
);

   entry_type entry_ff;
   entry_type entry_in;

   // A held entry stays put on an insert only if it is strictly smaller, so
   // a new entry lands ahead of any with an equal key.
   assign keep = occupied && (entry_ff.key < cmd.entry.key);

   always_comb begin
      entry_in = entry_ff;
      if (cmd.insert) begin
         if (!keep) begin
            entry_in = left_keep ? cmd.entry : left_entry;
         end
      end else if (cmd.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

/* src/sorted_priority_queue.sv */
// ---------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue kept in ascending key order in a chain of cells.
// ---------------------------------------------------------------------------
// A result is valid in the cycle after its request beat is accepted.
// Throughput: one operation per cycle while the result is not stalled; every cell updates in the same edge.
// The output register frees the input whenever the result is taken.
// Reset clears the entry count and the result valid; the cells' contents
// are not cleared and are only read below the entry count.
module sorted_priority_queue
   import spq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  logic    req_op,
   input  key_type req_new_key,
   input  tag_type req_new_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output logic    rsp_popped_valid,
   output key_type rsp_popped_key,
   output tag_type rsp_popped_payload,
   output logic    rsp_overflow,
   output logic    rsp_head_valid,
   output key_type rsp_head_key,
   output tag_type rsp_head_payload,
   output count_type rsp_entry_count
);

   localparam count_type FULL_COUNT = count_type'(DEPTH);

   count_type count_ff, count_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      popped_valid_ff, popped_valid_in;
   entry_type popped_ff, popped_in;
   logic      overflow_ff, overflow_in;
   logic      head_valid_ff, head_valid_in;
   entry_type head_ff, head_in;
   count_type entry_count_ff;

   logic      accept;
   logic      full;
   logic      empty;
   cmd_type   cmd;

   logic      keep       [DEPTH];
   entry_type entry      [DEPTH];
   entry_type entry_next [DEPTH];

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign full      = (count_ff == FULL_COUNT);
   assign empty     = (count_ff == '0);

   assign cmd.insert        = accept && (req_op == OP_INSERT) && !full;
   assign cmd.pop           = accept && (req_op == OP_POP) && !empty;
   assign cmd.entry.key     = req_new_key;
   assign cmd.entry.payload = req_new_payload;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam count_type INDEX = count_type'(i);
      logic      occupied;
      logic      left_keep;
      entry_type left_entry;
      entry_type right_entry;

      assign occupied = (INDEX < count_ff);

      if (i == 0) begin : g_first
         // The first slot has nothing to its left: a displaced slot here
         // always takes the new entry.
         assign left_keep  = 1'b1;
         assign left_entry = '0;
      end else begin : g_inner
         assign left_keep  = keep[i-1];
         assign left_entry = entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_body
         assign right_entry = entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (occupied),
         .left_keep   (left_keep),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .keep        (keep[i]),
         .entry       (entry[i]),
         .entry_next  (entry_next[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + count_type'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - count_type'(1);
      end
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      popped_valid_in = popped_valid_ff;
      popped_in       = popped_ff;
      overflow_in     = overflow_ff;
      head_valid_in   = head_valid_ff;
      head_in         = head_ff;
      if (accept) begin
         rsp_valid_in    = 1'b1;
         popped_valid_in = cmd.pop;
         popped_in       = cmd.pop ? entry[0] : '0;
         overflow_in     = (req_op == OP_INSERT) && full;
         head_valid_in   = (count_in != '0);
         head_in         = (count_in != '0) ? entry_next[0] : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      popped_valid_ff <= popped_valid_in;
      popped_ff       <= popped_in;
      overflow_ff     <= overflow_in;
      head_valid_ff   <= head_valid_in;
      head_ff         <= head_in;
      if (accept) begin
         entry_count_ff <= count_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_popped_valid   = popped_valid_ff;
   assign rsp_popped_key     = popped_ff.key;
   assign rsp_popped_payload = popped_ff.payload;
   assign rsp_overflow       = overflow_ff;
   assign rsp_head_valid     = head_valid_ff;
   assign rsp_head_key       = head_ff.key;
   assign rsp_head_payload   = head_ff.payload;
   assign rsp_entry_count    = entry_count_ff;

   // The entry count never goes past the number of cells.
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("entry count exceeds depth");

   // A dropped insert leaves the store full until the next beat.
   a_overflow_full : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && overflow_ff |-> full)
      else $error("overflow reported while store not full");

   // The reported head is valid exactly when the reported count is non-zero.
   a_head_count : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (head_valid_ff == (entry_count_ff != '0)))
      else $error("head valid disagrees with entry count");

   // An accepted pop on a non-empty store lowers the count by one.
   a_pop_count : assert property (@(posedge clock) disable iff (reset)
      cmd.pop |=> count_ff == $past(count_ff) - count_type'(1))
      else $error("pop did not lower the entry count");

endmodule

/* tb/sorted_priority_queue_checker.sv */
// ---------------------------------------------------------------------------
// sorted_priority_queue_checker
// Watches both channels of the sorted priority queue, keeps a shadow copy of
// the sorted store, predicts every result beat and compares it field by field.
// ---------------------------------------------------------------------------
module sorted_priority_queue_checker
   import spq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_valid,
   input  logic      req_stall,
   input  logic      req_op,
   input  key_type   req_new_key,
   input  tag_type   req_new_payload,
   input  logic      rsp_valid,
   input  logic      rsp_stall,
   input  logic      rsp_popped_valid,
   input  key_type   rsp_popped_key,
   input  tag_type   rsp_popped_payload,
   input  logic      rsp_overflow,
   input  logic      rsp_head_valid,
   input  key_type   rsp_head_key,
   input  tag_type   rsp_head_payload,
   input  count_type rsp_entry_count,
   output int        fail_count,
   output int        pending_count,
   output int        overflow_count,
   output int        empty_pop_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic      popped_valid;
      key_type   popped_key;
      tag_type   popped_payload;
      logic      overflow;
      logic      head_valid;
      key_type   head_key;
      tag_type   head_payload;
      count_type entry_count;
   } outcome_type;

   key_type     shadow_keys [DEPTH];
   tag_type     shadow_tags [DEPTH];
   int          shadow_count;
   outcome_type expected_outcomes [$];

   // Applies one operation to the shadow store and returns the result beat
   // that the queue should give for it.
   function automatic outcome_type model_queue_op(op_type op, key_type key, tag_type tag);
      outcome_type o;
      int          pos;
      o = '0;
      if (op == OP_INSERT) begin
         if (shadow_count >= DEPTH) begin
            o.overflow = 1'b1;
         end else begin
            pos = 0;
            // Stopping at the first key not below the new one puts the new
            // entry ahead of any equal keys.
            while (pos < shadow_count && shadow_keys[pos] < key) pos++;
            for (int i = shadow_count; i > pos; i--) begin
               shadow_keys[i] = shadow_keys[i-1];
               shadow_tags[i] = shadow_tags[i-1];
            end
            shadow_keys[pos] = key;
            shadow_tags[pos] = tag;
            shadow_count++;
         end
      end else if (shadow_count > 0) begin
         o.popped_valid   = 1'b1;
         o.popped_key     = shadow_keys[0];
         o.popped_payload = shadow_tags[0];
         for (int i = 1; i < shadow_count; i++) begin
            shadow_keys[i-1] = shadow_keys[i];
            shadow_tags[i-1] = shadow_tags[i];
         end
         shadow_count--;
      end
      if (shadow_count > 0) begin
         o.head_valid   = 1'b1;
         o.head_key     = shadow_keys[0];
         o.head_payload = shadow_tags[0];
      end
      o.entry_count = count_type'(shadow_count);
      return o;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         shadow_count    = 0;
         expected_outcomes.delete();
         fail_count      = 0;
         pending_count   = 0;
         overflow_count  = 0;
         empty_pop_count = 0;
      end else begin
         // A result beat always belongs to an earlier request beat, so it is
         // compared before this edge's request is added.
         if (rsp_valid && !rsp_stall) begin
            if (expected_outcomes.size() == 0) begin
               $display("%0t ns: result beat with no expectation waiting", $time);
               fail_count++;
            end else begin
               want = expected_outcomes.pop_front();
               check_field("popped_valid", want.popped_valid, rsp_popped_valid);
               check_field("popped_key", want.popped_key, rsp_popped_key);
               check_field("popped_payload", want.popped_payload, rsp_popped_payload);
               check_field("overflow", want.overflow, rsp_overflow);
               check_field("head_valid", want.head_valid, rsp_head_valid);
               check_field("head_key", want.head_key, rsp_head_key);
               check_field("head_payload", want.head_payload, rsp_head_payload);
               check_field("entry_count", want.entry_count, rsp_entry_count);
            end
         end
         if (req_valid && !req_stall) begin
            want = model_queue_op(op_type'(req_op), req_new_key, req_new_payload);
            if (want.overflow) overflow_count++;
            if (req_op == OP_POP && !want.popped_valid) empty_pop_count++;
            expected_outcomes.push_back(want);
         end
         pending_count = expected_outcomes.size();
      end
   end

endmodule

/* tb/sorted_priority_queue_tb.sv */
// ---------------------------------------------------------------------------
// sorted_priority_queue_tb
// Drives inserts and pops into the sorted priority queue with random gaps
// and back-pressure, fills and empties the store, and reports the verdict
// from the checker's failure count.
// ---------------------------------------------------------------------------
module sorted_priority_queue_tb
   import spq_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 200;
   localparam int SETTLE      = 8;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   logic      req_op;
   key_type   req_new_key;
   tag_type   req_new_payload;
   logic      rsp_valid;
   logic      rsp_stall;
   logic      rsp_popped_valid;
   key_type   rsp_popped_key;
   tag_type   rsp_popped_payload;
   logic      rsp_overflow;
   logic      rsp_head_valid;
   key_type   rsp_head_key;
   tag_type   rsp_head_payload;
   count_type rsp_entry_count;

   int fail_count;
   int pending_count;
   int overflow_count;
   int empty_pop_count;

   int   cycle_count;
   int   insert_total;
   int   pop_total;
   logic steady_source;
   logic steady_sink;
   logic hold_off_req;

   sorted_priority_queue u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_new_key        (req_new_key),
      .req_new_payload    (req_new_payload),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_popped_valid   (rsp_popped_valid),
      .rsp_popped_key     (rsp_popped_key),
      .rsp_popped_payload (rsp_popped_payload),
      .rsp_overflow       (rsp_overflow),
      .rsp_head_valid     (rsp_head_valid),
      .rsp_head_key       (rsp_head_key),
      .rsp_head_payload   (rsp_head_payload),
      .rsp_entry_count    (rsp_entry_count)
   );

   sorted_priority_queue_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_new_key        (req_new_key),
      .req_new_payload    (req_new_payload),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_popped_valid   (rsp_popped_valid),
      .rsp_popped_key     (rsp_popped_key),
      .rsp_popped_payload (rsp_popped_payload),
      .rsp_overflow       (rsp_overflow),
      .rsp_head_valid     (rsp_head_valid),
      .rsp_head_key       (rsp_head_key),
      .rsp_head_payload   (rsp_head_payload),
      .rsp_entry_count    (rsp_entry_count),
      .fail_count         (fail_count),
      .pending_count      (pending_count),
      .overflow_count     (overflow_count),
      .empty_pop_count    (empty_pop_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, pending_count);
      $display("end of test: mismatches");
      $finish;
   end

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap(logic steady);
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // Keys lean towards the extremes and a narrow band, so that equal keys
   // turn up often enough to test their ordering.
   function automatic key_type pick_key();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return key_type'($urandom_range(0, 7));
         default: return key_type'($urandom);
      endcase
   endfunction

   // Receiver: random stalls, plus one long hold-off each time the request
   // flag toggles.
   initial begin
      int   stall_left;
      logic hold_seen;
      stall_left = 0;
      hold_seen  = 1'b0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_req != hold_seen) begin
            hold_seen  = hold_off_req;
            stall_left = HOLD_CYCLES;
         end else if (stall_left == 0 && !steady_sink && $urandom_range(0, 99) < 20) begin
            stall_left = pick_gap(1'b0) + 1;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Called at a falling edge; returns at a falling edge with the beat taken.
   task automatic send_beat(op_type op, key_type key, tag_type tag);
      int gap;
      req_valid       <= 1'b1;
      req_op          <= op;
      req_new_key     <= key;
      req_new_payload <= tag;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_INSERT) insert_total++;
      else pop_total++;
      gap = pick_gap(steady_source);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   task automatic run_random(int count, int insert_pct);
      op_type op;
      for (int n = 0; n < count; n++) begin
         op = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_POP;
         send_beat(op, pick_key(), tag_type'($urandom));
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_op          = OP_INSERT;
      req_new_key     = '0;
      req_new_payload = '0;
      steady_source   = 1'b1;
      steady_sink     = 1'b1;
      hold_off_req    = 1'b0;
      insert_total    = 0;
      pop_total       = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: empty pops, extreme keys and payloads, ties at equal keys.
      send_beat(OP_POP, '0, '0);
      send_beat(OP_INSERT, '0, 16'h0000);
      send_beat(OP_INSERT, '1, 16'hffff);
      send_beat(OP_INSERT, 32'd7, 16'h0001);
      send_beat(OP_INSERT, 32'd7, 16'h0002);
      send_beat(OP_INSERT, 32'd7, 16'h0003);
      send_beat(OP_INSERT, 32'h8000_0000, 16'h8000);
      send_beat(OP_INSERT, 32'd1, 16'haaaa);
      send_beat(OP_INSERT, 32'hffff_fffe, 16'h5555);
      repeat (8) send_beat(OP_POP, '1, '1);
      send_beat(OP_POP, '0, '0);
      send_beat(OP_INSERT, '0, 16'hffff);
      send_beat(OP_INSERT, '0, 16'h0000);
      send_beat(OP_POP, '0, '0);
      send_beat(OP_POP, '0, '0);
      send_beat(OP_POP, '0, '0);

      // Mostly inserts, first back to back with no stalls, then with gaps and stalls, to fill the store.
      run_random(60, 95);
      steady_sink   = 1'b0;
      steady_source = 1'b0;
      run_random(60, 90);

      // The sender pauses until every result has come back.
      wait_for_drain();
      run_random(100, 15);

      // Long hold-off at the output while the sender keeps offering beats.
      wait_for_drain();
      steady_source = 1'b1;
      hold_off_req  = ~hold_off_req;
      run_random(90, 60);
      steady_source = 1'b0;

      run_random(400, 52);
      run_random(40, 10);

      wait_for_drain();
      repeat (SETTLE) @(negedge clock);
      $display("Sent %0d inserts and %0d pops in %0d cycles.",
               insert_total, pop_total, cycle_count);
      $display("%0d inserts were dropped on a full store, %0d pops found it empty.",
               overflow_count, empty_pop_count);
      if (fail_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
